// ===== rtl/bdk_pkg.sv =====
// shared types and constants of the background difference keyer
package bdk_pkg;

  localparam int CHAN_W      = 8;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int PROD_W      = 2 * CFG_DATA_W;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd240;
  localparam logic [CHAN_W-1:0]     THRESHOLD_RST    = 8'd48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic capture;
    logic last;
  } pixel_ctrl_t;

endpackage

// ===== rtl/bdk_ctrl.sv =====
// configuration registers, pixel position and capture decision
module bdk_ctrl #(
  parameter int MAX_PIXELS = 131072,
  parameter int POS_W      = 17
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bdk_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bdk_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             accept,
  input  logic                             capture_req,
  output logic [POS_W-1:0]                 pos,
  output bdk_pkg::pixel_ctrl_t             ctrl,
  output logic [bdk_pkg::SQ_W-1:0]         thr_sq
);
  import bdk_pkg::*;

  localparam logic [PROD_W-1:0] MAX_N = PROD_W'(MAX_PIXELS);

  // last index of a frame: empty sizes give one pixel, large ones saturate
  function automatic logic [POS_W-1:0] frame_last(input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] n;
    n = prod;
    if (n == '0) n = PROD_W'(1);
    if (n > MAX_N) n = MAX_N;
    return POS_W'(n - PROD_W'(1));
  endfunction

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [POS_W-1:0]      pixel_last;
  logic [POS_W-1:0]      pixel_position;
  logic                  backdrop_filled;
  logic                  capturing_frame;

  logic [CFG_DATA_W-1:0] mul_a;
  logic [CFG_DATA_W-1:0] mul_b;
  logic [PROD_W-1:0]     size_prod;
  logic                  size_write;
  logic [POS_W-1:0]      pos_eff;
  logic                  first;
  logic                  capture_now;

  always_comb begin
    size_write = cfg_write && ((cfg_index == REG_FRAME_WIDTH) ||
                               (cfg_index == REG_FRAME_HEIGHT));
    mul_a      = (cfg_index == REG_FRAME_WIDTH)  ? cfg_data : frame_width;
    mul_b      = (cfg_index == REG_FRAME_HEIGHT) ? cfg_data : frame_height;
    size_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      thr_sq       <= SQ_W'(THRESHOLD_RST) * SQ_W'(THRESHOLD_RST);
      pixel_last   <= frame_last(PROD_W'(FRAME_WIDTH_RST) * PROD_W'(FRAME_HEIGHT_RST));
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
          pixel_last  <= frame_last(size_prod);
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          pixel_last   <= frame_last(size_prod);
        end
        REG_DIFF_THRESHOLD: begin
          thr_sq <= SQ_W'(cfg_data[CHAN_W-1:0]) * SQ_W'(cfg_data[CHAN_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // a position past a shrunken frame restarts the frame
  always_comb begin
    pos_eff      = (pixel_position > pixel_last) ? '0 : pixel_position;
    first        = (pos_eff == '0);
    capture_now  = first ? (!backdrop_filled || capture_req) : capturing_frame;
    pos          = pos_eff;
    ctrl.capture = capture_now;
    ctrl.last    = (pos_eff == pixel_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position  <= '0;
      capturing_frame <= 1'b0;
    end else if (accept) begin
      pixel_position  <= ctrl.last ? '0 : pos_eff + POS_W'(1);
      capturing_frame <= capture_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backdrop_filled <= 1'b0;
    end else if (size_write) begin
      backdrop_filled <= 1'b0;
    end else if (accept && first && capture_now) begin
      backdrop_filled <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_empty_store_captures: assert property (@(posedge clk) disable iff (rst)
    (accept && first && !backdrop_filled) |-> ctrl.capture)
    else $error("first pixel with empty backdrop not captured");

  a_capture_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && first && capture_now && !cfg_write) |=> backdrop_filled)
    else $error("captured frame did not mark backdrop filled");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.last) |=> (pixel_position == '0))
    else $error("position did not wrap after last pixel");
`endif

endmodule

// ===== rtl/bdk_store.sv =====
// backdrop frame memory, one write or one registered read per cycle
module bdk_store #(
  parameter int DEPTH  = 131072,
  parameter int ADDR_W = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  bdk_pkg::rgb_t     wdata,
  output bdk_pkg::rgb_t     rdata
);
  import bdk_pkg::*;

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/bdk_dist.sv =====
// squared rgb distance stage and matte result register
module bdk_dist (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  bdk_pkg::rgb_t            pix,
  input  bdk_pkg::rgb_t            bg,
  input  bdk_pkg::pixel_ctrl_t     ctrl,
  input  logic [bdk_pkg::SQ_W-1:0] thr_sq,
  input  logic                     out_stall,
  output logic                     in_ready,
  output logic                     out_valid,
  output logic                     foreground,
  output logic                     frame_end
);
  import bdk_pkg::*;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic            s2_valid;
  logic [SQ_W-1:0] s2_sq_red;
  logic [SQ_W-1:0] s2_sq_green;
  logic [SQ_W-1:0] s2_sq_blue;
  logic            s2_last;
  logic            s2_adv;
  logic [DIST_W-1:0] dist_sum;

  assign s2_adv   = !out_valid || !out_stall;
  assign in_ready = !s2_valid || s2_adv;
  assign dist_sum = DIST_W'(s2_sq_red) + DIST_W'(s2_sq_green) + DIST_W'(s2_sq_blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_valid;
    end
  end

  // a captured pixel is compared against itself
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2_sq_red   <= ctrl.capture ? '0 : sq_diff(pix.red, bg.red);
      s2_sq_green <= ctrl.capture ? '0 : sq_diff(pix.green, bg.green);
      s2_sq_blue  <= ctrl.capture ? '0 : sq_diff(pix.blue, bg.blue);
      s2_last     <= ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid) begin
      foreground <= (dist_sum >= DIST_W'(thr_sq));
      frame_end  <= s2_last;
    end
  end

endmodule

// ===== rtl/background_difference_keyer.sv =====
// top level of the background difference keyer
//
//   channel   handshake                  payload
//   pixel     pixel_valid / pixel_stall  red, green, blue, capture
//   matte     matte_valid / matte_stall  foreground, frame_end
//   config    cfg_write                  cfg_index, cfg_data
//
// one pixel beat per clock unless stalled; beats pass the s1, s2 and matte registers
// the rate is set by the backdrop memory: one write or one read per beat
// reset clears position, filled flag and registers; backdrop memory is not cleared
// a stalled matte beat holds its stage, and the pixel side stalls once all
// three stages are full
module background_difference_keyer #(
  parameter int MAX_PIXELS = 131072
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  logic [bdk_pkg::CHAN_W-1:0]      red,
  input  logic [bdk_pkg::CHAN_W-1:0]      green,
  input  logic [bdk_pkg::CHAN_W-1:0]      blue,
  input  logic                            capture,
  output logic                            matte_valid,
  input  logic                            matte_stall,
  output logic                            foreground,
  output logic                            frame_end,
  input  logic                            cfg_write,
  input  logic [bdk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdk_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bdk_pkg::*;

  localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic              accept;
  logic [POS_W-1:0]  pos;
  pixel_ctrl_t       ctrl;
  logic [SQ_W-1:0]   thr_sq;
  rgb_t              pix;

  // stage one: pixel register beside the memory read register
  logic              s1_valid;
  rgb_t              s1_pix;
  pixel_ctrl_t       s1_ctrl;
  rgb_t              s1_bg;
  logic              s1_ready;

  assign pix         = '{red: red, green: green, blue: blue};
  assign pixel_stall = s1_valid && !s1_ready;
  assign accept      = pixel_valid && !pixel_stall;

  bdk_ctrl #(
    .MAX_PIXELS (MAX_PIXELS),
    .POS_W      (POS_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .capture_req (capture),
    .pos         (pos),
    .ctrl        (ctrl),
    .thr_sq      (thr_sq)
  );

  // captured pixels are written, all others fetch their backdrop entry
  bdk_store #(
    .DEPTH  (MAX_PIXELS),
    .ADDR_W (POS_W)
  ) u_store (
    .clk   (clk),
    .en    (accept),
    .we    (ctrl.capture),
    .addr  (pos),
    .wdata (pix),
    .rdata (s1_bg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pix;
      s1_ctrl <= ctrl;
    end
  end

  bdk_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .pix        (s1_pix),
    .bg         (s1_bg),
    .ctrl       (s1_ctrl),
    .thr_sq     (thr_sq),
    .out_stall  (matte_stall),
    .in_ready   (s1_ready),
    .out_valid  (matte_valid),
    .foreground (foreground),
    .frame_end  (frame_end)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (s1_valid && matte_valid && matte_stall))
    else $error("pixel side stalled with room in the pipeline");

  a_capture_carried: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1_valid && (s1_ctrl.capture == $past(ctrl.capture))))
    else $error("accepted beat lost in stage one");
`endif

endmodule

// ===== tb/bdk_matte_checker.sv =====
// matte checker: predicts the keyer's output beats and compares them as they leave
module bdk_matte_checker #(
  parameter int MAX_PIXELS = 131072
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  input  logic                            pixel_stall,
  input  logic [bdk_pkg::CHAN_W-1:0]      red,
  input  logic [bdk_pkg::CHAN_W-1:0]      green,
  input  logic [bdk_pkg::CHAN_W-1:0]      blue,
  input  logic                            capture,
  input  logic                            matte_valid,
  input  logic                            matte_stall,
  input  logic                            foreground,
  input  logic                            frame_end,
  input  logic                            cfg_write,
  input  logic [bdk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdk_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  import bdk_pkg::*;

  typedef struct packed {
    logic foreground;
    logic frame_end;
  } matte_t;

  // predicted keyer state
  rgb_t                  bg_mem [MAX_PIXELS];
  int unsigned           pix_pos;
  logic                  bg_valid;
  logic                  bg_grab;
  logic [CFG_DATA_W-1:0] cfg_w;
  logic [CFG_DATA_W-1:0] cfg_h;
  logic [CHAN_W-1:0]     cfg_thr;
  matte_t                matte_q [$];

  function automatic int unsigned frame_size();
    int unsigned n;
    n = 32'(cfg_w) * 32'(cfg_h);
    if (n == 0) n = 1;
    if (n > MAX_PIXELS) n = MAX_PIXELS;
    return n;
  endfunction

  function automatic int unsigned sq_dist(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int d;
    d = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d * d;
  endfunction

  function automatic matte_t key_pixel(rgb_t px, logic cap);
    int unsigned npix;
    int unsigned dist_sum;
    int unsigned thr_sq;
    rgb_t        bg_px;
    matte_t      m;
    npix = frame_size();
    if (pix_pos >= npix) pix_pos = 0;
    if (pix_pos == 0) begin
      bg_grab = !bg_valid || cap;
      if (bg_grab) bg_valid = 1'b1;
    end
    if (bg_grab) bg_mem[pix_pos] = px;
    bg_px    = bg_mem[pix_pos];
    dist_sum = sq_dist(px.red, bg_px.red) + sq_dist(px.green, bg_px.green)
             + sq_dist(px.blue, bg_px.blue);
    thr_sq   = 32'(cfg_thr) * 32'(cfg_thr);
    m.foreground = (dist_sum >= thr_sq);
    m.frame_end  = (pix_pos == npix - 1);
    pix_pos = m.frame_end ? 0 : pix_pos + 1;
    return m;
  endfunction

  always @(posedge clk) begin : monitor
    matte_t got;
    matte_t want;
    if (rst) begin
      pix_pos  = 0;
      bg_valid = 1'b0;
      bg_grab  = 1'b0;
      cfg_w    = FRAME_WIDTH_RST;
      cfg_h    = FRAME_HEIGHT_RST;
      cfg_thr  = THRESHOLD_RST;
      matte_q.delete();
    end else begin
      // compare first, so a beat can never match the pixel taken at the same edge
      if (matte_valid && !matte_stall) begin
        got.foreground = foreground;
        got.frame_end  = frame_end;
        if (matte_q.size() == 0) begin
          fail_count++;
          $display("%0t: extra matte beat, expected none, got foreground %0b frame_end %0b",
                   $time, got.foreground, got.frame_end);
        end else begin
          want = matte_q.pop_front();
          if (got.foreground !== want.foreground) begin
            fail_count++;
            $display("%0t: foreground mismatch, expected %0b, got %0b",
                     $time, want.foreground, got.foreground);
          end
          if (got.frame_end !== want.frame_end) begin
            fail_count++;
            $display("%0t: frame_end mismatch, expected %0b, got %0b",
                     $time, want.frame_end, got.frame_end);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH: begin
            cfg_w    = cfg_data;
            bg_valid = 1'b0;
          end
          REG_FRAME_HEIGHT: begin
            cfg_h    = cfg_data;
            bg_valid = 1'b0;
          end
          REG_DIFF_THRESHOLD: begin
            cfg_thr = cfg_data[CHAN_W-1:0];
          end
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall)
        matte_q.push_back(key_pixel(rgb_t'({red, green, blue}), capture));
    end
    pending = matte_q.size();
  end

endmodule

// ===== tb/background_difference_keyer_tb.sv =====
// testbench top of the background difference keyer: stimulus, idling and verdict
module background_difference_keyer_tb;
  import bdk_pkg::*;

  localparam int MAX_PIXELS    = 131072;
  localparam int RANDOM_PIXELS = 750;

  logic                   clk;
  logic                   rst;
  logic                   pixel_valid;
  logic                   pixel_stall;
  logic [CHAN_W-1:0]      red;
  logic [CHAN_W-1:0]      green;
  logic [CHAN_W-1:0]      blue;
  logic                   capture;
  logic                   matte_valid;
  logic                   matte_stall;
  logic                   foreground;
  logic                   frame_end;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned fail_count;
  int unsigned pending;

  // idle_on enables random gaps on both sides; hold_len asks the matte side
  // for one long hold-off
  bit   idle_on;
  int   hold_len;

  // last pixel sent at each frame position; new frames are small variations
  // of it, so pixels land on both sides of the threshold
  rgb_t last_sent [MAX_PIXELS];

  background_difference_keyer #(
    .MAX_PIXELS(MAX_PIXELS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .capture     (capture),
    .matte_valid (matte_valid),
    .matte_stall (matte_stall),
    .foreground  (foreground),
    .frame_end   (frame_end),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  bdk_matte_checker #(
    .MAX_PIXELS(MAX_PIXELS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .capture     (capture),
    .matte_valid (matte_valid),
    .matte_stall (matte_stall),
    .foreground  (foreground),
    .frame_end   (frame_end),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // matte side: random stall bursts while idling is on, plus the one long
  // hold-off counted here in cycles
  initial begin
    matte_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        matte_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len    = 0;
        matte_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        matte_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        matte_stall = 1'b0;
      end
    end
  end

  // register write; only called with no pixel offered and nothing in flight
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // drop valid and wait until every pixel has come back as a matte beat;
  // one beat out per beat in, so the pipeline is empty then
  task automatic wait_drained();
    pixel_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // offer one pixel beat and hold it until taken; returns at the next falling
  // edge with valid still high, so back-to-back beats leave no bubble
  task automatic send_pixel(rgb_t px, logic cap);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pixel_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    pixel_valid        = 1'b1;
    {red, green, blue} = px;
    capture            = cap;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  function automatic rgb_t any_pixel();
    return rgb_t'(24'($urandom()));
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  // one whole frame starting at position zero; the capture bit only counts on
  // the first pixel, the rest get random noise there
  task automatic send_frame(int unsigned npix, logic cap);
    rgb_t        px;
    int          spread;
    int unsigned mode;
    for (int unsigned p = 0; p < npix; p++) begin
      mode   = $urandom_range(0, 9);
      spread = $urandom_range(1, 48);
      px     = last_sent[p];
      if (mode < 2) begin
        px = any_pixel();
      end else if (mode > 2) begin
        // mode 2 repeats the pixel exactly, the rest drift a little
        px.red   = nudge(px.red, spread);
        px.green = nudge(px.green, spread);
        px.blue  = nudge(px.blue, spread);
      end
      last_sent[p] = px;
      send_pixel(px, (p == 0) ? cap : 1'($urandom()));
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned sent;
    int unsigned phase;
    rst         = 1'b1;
    pixel_valid = 1'b0;
    red         = '0;
    green       = '0;
    blue        = '0;
    capture     = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    idle_on     = 1'b0;
    hold_len    = 0;
    w           = 1;
    h           = 1;
    foreach (last_sent[i]) last_sent[i] = any_pixel();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----

    // 2x2 frames; with a zero threshold every pixel keys as foreground, and
    // the first frame after reset is captured whatever its capture bit says
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(0));
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hffffff, 1'b1);
    send_pixel(24'hff0000, 1'b1);
    send_pixel(24'h00ff00, 1'b0);

    // largest threshold against full-scale channel differences; the store is
    // filled now, so capture low means compare only
    wait_drained();
    write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(255));
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hff0000, 1'b0);
    send_pixel(24'h0000ff, 1'b0);

    // capture request on an already filled store
    wait_drained();
    write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(1));
    send_frame(4, 1'b1);

    // frame grows while half done: the frame runs on to the new size and
    // keeps capturing
    send_pixel(any_pixel(), 1'b1);
    send_pixel(any_pixel(), 1'b0);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    repeat (4) send_pixel(any_pixel(), 1'b0);

    // frame shrinks below the current position: the next pixel opens a new
    // frame, captured because the size write cleared the filled flag
    send_pixel(any_pixel(), 1'b1);
    repeat (3) send_pixel(any_pixel(), 1'b0);
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
    repeat (3) send_pixel(any_pixel(), 1'b0);

    // zero width or zero height collapses the frame to one pixel
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(0));
    send_pixel(any_pixel(), 1'b0);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2047));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(0));
    send_pixel(any_pixel(), 1'b0);
    send_pixel(any_pixel(), 1'b0);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2047));
    send_pixel(any_pixel(), 1'b0);

    // ---- random part ----
    // each phase starts drained (the sender waits for every matte beat),
    // may resize or retune, then sends whole frames; a resize always forces a
    // fresh capture, so the store never gets read where it was not written
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_drained();
      phase++;
      // idling in most phases, none in the closing stretch
      idle_on = (sent + 150 < RANDOM_PIXELS) && ($urandom_range(0, 3) != 0);
      if (phase == 1 || $urandom_range(0, 2) == 0) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) begin
          w = $urandom_range(13, 64);
          h = 1;
        end
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(0));
          1:       write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(255));
          2:       write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'($urandom_range(1, 64)));
          default: write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
        endcase
      end
      repeat ($urandom_range(1, 4)) begin
        send_frame(w * h, $urandom_range(0, 3) == 0);
        sent += w * h;
      end
    end

    // ---- saturated frame ----
    // 1024 x 1024 is clipped to MAX_PIXELS pixels; only the head of the frame
    // is sent, and the matte side holds off at the start while pixels keep
    // coming, so the pixel side must stall
    wait_drained();
    idle_on = 1'b0;
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(1024));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1024));
    write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
    hold_len = 64;
    send_frame(64, 1'b1);

    // everything back, then a quiet stretch to catch stray beats
    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdk_pkg.sv
rtl/bdk_ctrl.sv
rtl/bdk_store.sv
rtl/bdk_dist.sv
rtl/background_difference_keyer.sv
tb/bdk_matte_checker.sv
tb/background_difference_keyer_tb.sv
